// ===== hdl/sitd_pkg.sv =====
// Shared constants and helpers for the signed integer to decimal text block.
// No dependencies; used by signed_int_to_decimal_text.
package sitd_pkg;

  localparam int NUMBER_W       = 64;
  localparam int CHAR_W         = 8;
  localparam int VALUE_BITS_DEF = 64;
  localparam int BCD_W          = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  // Digits needed for magnitudes up to 2^(bits-1); floor(0.3*bits)+1 covers it.
  function automatic int num_digits(input int bits);
    return (bits * 3) / 10 + 1;
  endfunction

  // Shift-add-3 correction for one BCD digit before the next left shift.
  function automatic logic [BCD_W-1:0] dd_adjust(input logic [BCD_W-1:0] d);
    return (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

endpackage

// ===== hdl/signed_int_to_decimal_text.sv =====
// Order: '-' (if negative) while the conversion runs, then the digits of the
// NDIG-digit field, most significant first, leading zeros dropped; the last
// char is flagged by out_last_char. busy stays high until the emit scan ends.
// A new item is taken only while idle, after the one-bit-per-cycle shift-add-3
// loop and the one-digit-per-cycle emit scan of the last one; no stalls.
// Sync active-low reset idles the sequencer, drops strobe.
module signed_int_to_decimal_text #(
  parameter int VALUE_BITS = sitd_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sitd_pkg::NUMBER_W-1:0] in_number,
  output logic                          out_valid,
  output logic [sitd_pkg::CHAR_W-1:0]   out_text_char,
  output logic                          out_last_char
);

  localparam int NDIG  = sitd_pkg::num_digits(VALUE_BITS);
  localparam int BW    = NDIG * sitd_pkg::BCD_W;
  localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic                           neg_r, neg_nxt;
  logic                           started_r, started_nxt;
  logic [VALUE_BITS-1:0]          mag_r, mag_nxt;
  logic [BW-1:0]                  bcd_r, bcd_nxt;
  logic [BW-1:0]                  bcd_adj;
  logic                           out_valid_r, out_valid_nxt;
  logic [sitd_pkg::CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                           out_last_r, out_last_nxt;
  logic [VALUE_BITS-1:0]          raw;
  logic [sitd_pkg::BCD_W-1:0]     top_digit;
  logic                           accept;

  assign raw       = in_number[VALUE_BITS-1:0];
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign top_digit = bcd_r[BW-1 -: sitd_pkg::BCD_W];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*sitd_pkg::BCD_W +: sitd_pkg::BCD_W] =
        sitd_pkg::dd_adjust(bcd_r[i*sitd_pkg::BCD_W +: sitd_pkg::BCD_W]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          neg_nxt   = raw[VALUE_BITS-1];
          mag_nxt   = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        // sign goes out while the conversion runs
        if (cnt_r == '0 && neg_r) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sitd_pkg::ASCII_MINUS;
        end
        bcd_nxt = {bcd_adj[BW-2:0], mag_r[VALUE_BITS-1]};
        mag_nxt = mag_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_BITS - 1)) begin
          idx_nxt     = IDX_W'(NDIG - 1);
          started_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // drop leading zeros, but always emit the units digit
        if (started_r || top_digit != '0 || idx_r == '0) begin
          started_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = sitd_pkg::ASCII_ZERO | {4'd0, top_digit};
          out_last_nxt  = (idx_r == '0);
        end
        bcd_nxt = bcd_r << sitd_pkg::BCD_W;
        idx_nxt = idx_r - 1'b1;
        if (idx_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

`ifndef SYNTHESIS
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_CONV)
    else $error("accepted item did not start conversion");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_char |-> (out_valid && state_r == ST_IDLE))
    else $error("last character flagged while still busy");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && idx_r != '0) |=> idx_r == $past(idx_r) - 1'b1)
    else $error("emit index skipped a digit");
  a_minus_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_text_char == sitd_pkg::ASCII_MINUS) |-> (neg_r && !out_last_char))
    else $error("minus sign for a non-negative item");
`endif

endmodule
